// ===== src/mhtq_pkg.sv =====
package mhtq_pkg;

	localparam int CMD_W = 3;
	localparam int STATUS_W = 2;
	localparam int TIME_W = 64;
	localparam int DUE_W = 63;
	localparam int EID_W = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD        = 3'd0,
		CMD_RESCHEDULE = 3'd1,
		CMD_DELETE     = 3'd2,
		CMD_POP        = 3'd3,
		CMD_PEEK       = 3'd4,
		CMD_CLEAR      = 3'd5
	} cmd_t;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;

endpackage

// ===== src/min_heap_timer_queue_top.sv =====
// Clear, an empty peek, an empty or negative-time pop and requests rejected at decode go
// from decode straight to the response; a peek or a pop with nothing due first reads the
// root. Add, reschedule and delete scan the ids one entry at a time, and each heap update
// sifts level by level, down and up.
// Throughput: one request at a time; in_stall is high while busy or while a result waits.
// Reset (arst_n low, asynchronous) empties the heap and zeroes the id sequence.
module min_heap_timer_queue_top
	import mhtq_pkg::*;
#(
	parameter int HEAP_DEPTH = 64,
	parameter int ID_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [CMD_W-1:0]           cmd,
	input  logic [EID_W-1:0]           event_id,
	input  logic signed [TIME_W-1:0]   timestamp,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [STATUS_W-1:0]        status,
	output logic [EID_W-1:0]           result_id,
	output logic signed [TIME_W-1:0]   next_time
);

	localparam int AW = (HEAP_DEPTH > 2) ? $clog2(HEAP_DEPTH) : 1;
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int IW = (ID_BITS > EID_W) ? ID_BITS : EID_W;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_DECODE = 12'b000000000010,
		S_SRCH   = 12'b000000000100,
		S_SRCHW  = 12'b000000001000,
		S_UPRD   = 12'b000000010000,
		S_UPCMP  = 12'b000000100000,
		S_DNRDL  = 12'b000001000000,
		S_DNRDR  = 12'b000010000000,
		S_DNCMP  = 12'b000100000000,
		S_MOVE   = 12'b001000000000,
		S_RESP   = 12'b010000000000,
		S_LASTRD = 12'b100000000000
	} state_t;

	typedef struct packed {
		logic [DUE_W-1:0] due;
		logic [IW-1:0]    id;
	} entry_t;

	state_t state_q;
	entry_t mem_q [HEAP_DEPTH];
	entry_t rd_q;
	logic [AW-1:0] raddr;
	logic          re;
	logic [AW-1:0] waddr;
	logic          we;
	entry_t        wdata;

	logic [CW-1:0] count_q;
	logic [IW-1:0] seq_q;
	logic [CMD_W-1:0] cmd_q;
	logic [IW-1:0] eid_q;
	logic [TIME_W-1:0] ts_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] pos_q;
	entry_t cur_q;
	entry_t best_q;
	logic [CW-1:0] bidx_q;
	logic [CW-1:0] child_q;
	logic up_q;
	logic [STATUS_W-1:0] st_q;
	logic [EID_W-1:0] rid_q;
	logic [TIME_W-1:0] nt_q;
	logic ov_q;

	logic less;
	entry_t cmp_a, cmp_b;
	logic [IW-1:0] seq_nx;

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_comb begin
		cmp_a = cur_q;
		cmp_b = rd_q;
		if (state_q == S_DNCMP) begin
			cmp_a = rd_q;
			cmp_b = best_q;
		end
		less = (cmp_a.due < cmp_b.due) || (cmp_a.due == cmp_b.due && cmp_a.id < cmp_b.id);
	end

	always_comb begin
		seq_nx = seq_q + 1'b1;
		if (ID_BITS < IW) begin
			seq_nx = seq_nx & ((IW'(1) << ID_BITS) - 1'b1);
		end
		if (seq_nx == '0) begin
			seq_nx = IW'(1);
		end
	end

	always_comb begin
		re = 1'b0;
		raddr = '0;
		we = 1'b0;
		waddr = '0;
		wdata = cur_q;
		unique case (state_q)
			S_DECODE: begin
				re = 1'b1;
				raddr = '0;
			end
			S_SRCH: begin
				re = 1'b1;
				raddr = idx_q[AW-1:0];
			end
			S_LASTRD: begin
				re = 1'b1;
				raddr = AW'(count_q);
			end
			S_UPRD: begin
				re = 1'b1;
				raddr = AW'((pos_q - 1'b1) >> 1);
			end
			S_UPCMP: begin
				if (pos_q != '0 && less) begin
					we = 1'b1;
					waddr = pos_q[AW-1:0];
					wdata = rd_q;
				end else begin
					we = 1'b1;
					waddr = pos_q[AW-1:0];
				end
			end
			S_DNRDL: begin
				re = 1'b1;
				raddr = child_q[AW-1:0];
			end
			S_DNRDR: begin
				re = 1'b1;
				raddr = AW'(child_q + 1'b1);
			end
			S_DNCMP: begin
			end
			S_MOVE: begin
				we = 1'b1;
				waddr = pos_q[AW-1:0];
				wdata = best_q;
			end
			default: begin
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE) || (ov_q && out_stall);
	assign out_valid = ov_q;
	assign status = st_q;
	assign result_id = rid_q;
	assign next_time = nt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			seq_q <= '0;
			ov_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !(ov_q && out_stall)) begin
						cmd_q <= cmd;
						eid_q <= IW'(event_id);
						ts_q <= timestamp;
						idx_q <= '0;
						st_q <= ST_REJECT;
						rid_q <= '0;
						nt_q <= '1;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q <= S_RESP;
					priority case (cmd_q)
						CMD_ADD: begin
							if (!ts_q[TIME_W-1] && count_q < CW'(HEAP_DEPTH)) begin
								seq_q <= seq_nx;
								eid_q <= seq_nx;
								state_q <= S_SRCH;
							end
						end
						CMD_RESCHEDULE: begin
							if (!ts_q[TIME_W-1]) begin
								state_q <= S_SRCH;
							end
						end
						CMD_DELETE: begin
							state_q <= S_SRCH;
						end
						CMD_POP: begin
							st_q <= ST_EMPTY;
							if (count_q != '0 && !ts_q[TIME_W-1]) begin
								state_q <= S_SRCHW;
								idx_q <= '1;
							end
						end
						CMD_PEEK: begin
							st_q <= ST_EMPTY;
							if (count_q != '0) begin
								state_q <= S_SRCHW;
								idx_q <= '1;
							end
						end
						CMD_CLEAR: begin
							count_q <= '0;
							seq_q <= '0;
							st_q <= ST_OK;
						end
						default: begin
						end
					endcase
				end
				S_SRCH: begin
					if (idx_q >= count_q) begin
						if (cmd_q == CMD_ADD) begin
							cur_q.due <= ts_q[DUE_W-1:0];
							cur_q.id <= eid_q;
							pos_q <= count_q;
							count_q <= count_q + 1'b1;
							st_q <= ST_OK;
							rid_q <= EID_W'(eid_q);
							state_q <= S_UPRD;
						end else begin
							state_q <= S_RESP;
						end
					end else begin
						state_q <= S_SRCHW;
					end
				end
				S_SRCHW: begin
					if (idx_q == '1) begin
						priority if (cmd_q == CMD_PEEK) begin
							st_q <= ST_OK;
							nt_q <= TIME_W'(rd_q.due);
							state_q <= S_RESP;
						end else if (TIME_W'(rd_q.due) > ts_q) begin
							state_q <= S_RESP;
						end else begin
							st_q <= ST_OK;
							rid_q <= EID_W'(rd_q.id);
							nt_q <= TIME_W'(rd_q.due);
							pos_q <= '0;
							count_q <= count_q - 1'b1;
							state_q <= S_LASTRD;
						end
					end else if (rd_q.id == eid_q) begin
						pos_q <= idx_q;
						priority if (cmd_q == CMD_ADD) begin
							state_q <= S_RESP;
						end else if (cmd_q == CMD_RESCHEDULE) begin
							st_q <= ST_OK;
							cur_q.due <= ts_q[DUE_W-1:0];
							cur_q.id <= rd_q.id;
							child_q <= CW'({idx_q, 1'b1});
							state_q <= S_DNRDL;
						end else begin
							st_q <= ST_OK;
							count_q <= count_q - 1'b1;
							state_q <= S_LASTRD;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_SRCH;
					end
				end
				S_LASTRD: begin
					if (pos_q == count_q) begin
						state_q <= S_RESP;
					end else begin
						state_q <= S_MOVE;
						best_q <= cur_q;
						child_q <= '1;
					end
				end
				S_MOVE: begin
					if (child_q == '1) begin
						cur_q <= rd_q;
						child_q <= CW'({pos_q, 1'b1});
						state_q <= S_DNRDL;
					end else begin
						pos_q <= bidx_q;
						child_q <= CW'({bidx_q, 1'b1});
						state_q <= S_DNRDL;
					end
				end
				S_DNRDL: begin
					best_q <= cur_q;
					bidx_q <= pos_q;
					if ({1'b0, child_q} >= {1'b0, count_q} || child_q < pos_q) begin
						state_q <= S_UPRD;
					end else begin
						state_q <= S_DNCMP;
						up_q <= 1'b0;
					end
				end
				S_DNCMP: begin
					if (less) begin
						best_q <= rd_q;
						bidx_q <= up_q ? child_q + 1'b1 : child_q;
					end
					if (!up_q && child_q + 1'b1 < count_q) begin
						up_q <= 1'b1;
						state_q <= S_DNRDR;
					end else if ((less ? (up_q ? child_q + 1'b1 : child_q) : bidx_q) == pos_q) begin
						state_q <= S_UPRD;
					end else begin
						state_q <= S_MOVE;
						child_q <= '0;
					end
				end
				S_DNRDR: begin
					state_q <= S_DNCMP;
				end
				S_UPRD: begin
					state_q <= S_UPCMP;
				end
				S_UPCMP: begin
					if (pos_q != '0 && less) begin
						pos_q <= (pos_q - 1'b1) >> 1;
						state_q <= S_UPRD;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!ov_q || !out_stall) begin
						ov_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (ov_q && !out_stall && state_q != S_RESP) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule

// ===== tb/sv/tb_min_heap_timer_queue_top.sv =====
module tb_min_heap_timer_queue_top;
	import mhtq_pkg::*;

	localparam int DEPTH = 64;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [EID_W-1:0] eid;
		logic signed [TIME_W-1:0] ts;
	} request_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [EID_W-1:0] rid;
		logic signed [TIME_W-1:0] nt;
	} response_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CMD_W-1:0] cmd = '0;
	logic [EID_W-1:0] event_id = '0;
	logic signed [TIME_W-1:0] timestamp = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic [STATUS_W-1:0] status;
	logic [EID_W-1:0] result_id;
	logic signed [TIME_W-1:0] next_time;

	request_t pending_reqs[$];
	response_t expected_resps[$];
	request_t cur_req;
	int idle_mode = 2;
	bit hold_go = 0;
	int hold_cnt = 0;
	int errors = 0;

	logic [DUE_W-1:0] due_times[DEPTH];
	logic [EID_W-1:0] event_ids[DEPTH];
	int entry_count = 0;
	logic [EID_W-1:0] id_seq = '0;

	min_heap_timer_queue_top u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
		.event_id(event_id), .timestamp(timestamp), .out_valid(out_valid),
		.out_stall(out_stall), .status(status), .result_id(result_id),
		.next_time(next_time)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit earlier(int a, int b);
		if (due_times[a] != due_times[b])
			return due_times[a] < due_times[b];
		return event_ids[a] < event_ids[b];
	endfunction

	function automatic void swap_slots(int a, int b);
		logic [DUE_W-1:0] t;
		logic [EID_W-1:0] e;
		t = due_times[a]; due_times[a] = due_times[b]; due_times[b] = t;
		e = event_ids[a]; event_ids[a] = event_ids[b]; event_ids[b] = e;
	endfunction

	function automatic void bubble_up(int i);
		int p;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!earlier(i, p))
				break;
			swap_slots(i, p);
			i = p;
		end
	endfunction

	function automatic void bubble_down(int i);
		int l, r, m;
		forever begin
			l = 2 * i + 1;
			r = l + 1;
			m = i;
			if (l < entry_count && earlier(l, m))
				m = l;
			if (r < entry_count && earlier(r, m))
				m = r;
			if (m == i)
				break;
			swap_slots(i, m);
			i = m;
		end
	endfunction

	function automatic int locate_id(logic [EID_W-1:0] id);
		for (int i = 0; i < entry_count; i++)
			if (event_ids[i] == id)
				return i;
		return -1;
	endfunction

	function automatic void remove_slot(int i);
		entry_count--;
		if (i != entry_count) begin
			due_times[i] = due_times[entry_count];
			event_ids[i] = event_ids[entry_count];
			bubble_down(i);
			bubble_up(i);
		end
	endfunction

	function automatic response_t apply_timer_request(request_t rq);
		response_t rs;
		bit neg;
		int pos;
		neg = rq.ts[TIME_W-1];
		rs.status = ST_REJECT;
		rs.rid = '0;
		rs.nt = -64'sd1;
		case (rq.cmd)
			CMD_ADD: begin
				if (!neg && entry_count < DEPTH) begin
					id_seq = id_seq + 1;
					if (id_seq == '0)
						id_seq = 1;
					if (locate_id(id_seq) < 0) begin
						due_times[entry_count] = rq.ts[DUE_W-1:0];
						event_ids[entry_count] = id_seq;
						entry_count++;
						bubble_up(entry_count - 1);
						rs.status = ST_OK;
						rs.rid = id_seq;
					end
				end
			end
			CMD_RESCHEDULE: begin
				pos = locate_id(rq.eid);
				if (!neg && pos >= 0) begin
					due_times[pos] = rq.ts[DUE_W-1:0];
					bubble_down(pos);
					bubble_up(pos);
					rs.status = ST_OK;
				end
			end
			CMD_DELETE: begin
				pos = locate_id(rq.eid);
				if (pos >= 0) begin
					remove_slot(pos);
					rs.status = ST_OK;
				end
			end
			CMD_POP: begin
				if (entry_count == 0 || neg || {1'b0, due_times[0]} > rq.ts)
					rs.status = ST_EMPTY;
				else begin
					rs.status = ST_OK;
					rs.rid = event_ids[0];
					rs.nt = {1'b0, due_times[0]};
					remove_slot(0);
				end
			end
			CMD_PEEK: begin
				if (entry_count == 0)
					rs.status = ST_EMPTY;
				else begin
					rs.status = ST_OK;
					rs.nt = {1'b0, due_times[0]};
				end
			end
			CMD_CLEAR: begin
				entry_count = 0;
				id_seq = '0;
				rs.status = ST_OK;
			end
			default: ;
		endcase
		return rs;
	endfunction

	function automatic bit sender_idles();
		if (idle_mode == 0)
			return $urandom_range(99) < 38;
		if (idle_mode == 1)
			return $urandom_range(99) < 55;
		return 0;
	endfunction

	function automatic bit receiver_idles();
		if (idle_mode == 0)
			return $urandom_range(99) < 55;
		if (idle_mode == 1)
			return $urandom_range(99) < 38;
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_resps = {expected_resps, apply_timer_request(cur_req)};
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() > 0 && !sender_idles()) begin
					cur_req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					cmd <= cur_req.cmd;
					event_id <= cur_req.eid;
					timestamp <= cur_req.ts;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		response_t want;
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_resps.size() == 0) begin
					errors++;
					$display("%0t: unexpected response status=%0d id=%0h time=%0d", $time,
						status, result_id, next_time);
				end else begin
					want = expected_resps.pop_front();
					if (status !== want.status || result_id !== want.rid
							|| next_time !== want.nt) begin
						errors++;
						$display("%0t: expected status=%0d id=%0h time=%0d, got %0d %0h %0d",
							$time, want.status, want.rid, want.nt, status, result_id,
							next_time);
					end
				end
			end
			if (hold_go && hold_cnt < HOLD_CYCLES) begin
				hold_cnt++;
				out_stall <= 1'b1;
			end else begin
				out_stall <= receiver_idles();
			end
		end
	end

	task automatic queue_req(logic [CMD_W-1:0] c, logic [EID_W-1:0] e,
			logic signed [TIME_W-1:0] t);
		request_t rq;
		rq.cmd = c;
		rq.eid = e;
		rq.ts = t;
		pending_reqs = {pending_reqs, rq};
	endtask

	function automatic logic signed [TIME_W-1:0] pick_time();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return TIME_W'($urandom_range(300));
		if (r < 80)
			return -$signed({32'd0, $urandom});
		return $signed({$urandom, $urandom});
	endfunction

	task automatic queue_random(int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(999);
			if (r < 8) begin
				for (int j = 0; j < 68; j++)
					queue_req(CMD_ADD, $urandom, TIME_W'($urandom_range(1000)));
			end else if (r < 30) begin
				queue_req(CMD_CLEAR, $urandom, pick_time());
			end else if (r < 40) begin
				queue_req(CMD_W'($urandom_range(7, 6)), $urandom, pick_time());
			end else if (r < 370) begin
				queue_req(CMD_ADD, $urandom, pick_time());
			end else if (r < 520) begin
				queue_req(CMD_RESCHEDULE, r < 500 ? $urandom_range(80) : $urandom,
					pick_time());
			end else if (r < 670) begin
				queue_req(CMD_DELETE, r < 650 ? $urandom_range(80) : $urandom, pick_time());
			end else if (r < 900) begin
				queue_req(CMD_POP, $urandom, pick_time());
			end else begin
				queue_req(CMD_PEEK, $urandom, pick_time());
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || in_valid || expected_resps.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		queue_req(CMD_PEEK, '0, '0);
		queue_req(CMD_POP, '0, 64'sh7fff_ffff_ffff_ffff);
		queue_req(CMD_ADD, 32'hffff_ffff, '0);
		queue_req(CMD_ADD, '0, 64'sh7fff_ffff_ffff_ffff);
		queue_req(CMD_ADD, '0, 64'sh8000_0000_0000_0000);
		queue_req(CMD_ADD, '0, 64'sd5);
		queue_req(CMD_ADD, '0, 64'sd5);
		queue_req(CMD_PEEK, '0, -64'sd1);
		queue_req(CMD_RESCHEDULE, 32'd1, 64'sd3);
		queue_req(CMD_RESCHEDULE, 32'd99, 64'sd3);
		queue_req(CMD_RESCHEDULE, 32'd2, -64'sd7);
		queue_req(CMD_DELETE, 32'd2, '0);
		queue_req(CMD_DELETE, '0, '0);
		queue_req(CMD_DELETE, 32'hffff_ffff, '0);
		queue_req(CMD_POP, '0, -64'sd1);
		queue_req(CMD_POP, '0, 64'sd2);
		queue_req(CMD_POP, '0, 64'sh7fff_ffff_ffff_ffff);
		queue_req(3'd6, 32'd3, 64'sd1);
		queue_req(3'd7, 32'd3, 64'sd1);
		queue_req(CMD_PEEK, '0, '0);
		queue_req(CMD_CLEAR, '0, '0);
		queue_req(CMD_PEEK, '0, '0);
		queue_req(CMD_ADD, '0, 64'sd10);
		wait_drained();
		idle_mode = 0;
		queue_random(650);
		wait_drained();
		idle_mode = 1;
		hold_go = 1;
		queue_random(650);
		wait_drained();
		idle_mode = 2;
		queue_random(650);
		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#40000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== min_heap_timer_queue_top.f =====
src/mhtq_pkg.sv
src/min_heap_timer_queue_top.sv
tb/sv/tb_min_heap_timer_queue_top.sv
